// ===== design/rfku_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfku_pkg: shared types and codes for the record queue
// Holds the word formats on the command and result ports, the operation and
// status codes, and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rfku_pkg;

    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_POP  = 3'd1;
    localparam logic [OP_W-1:0] OP_DUMP = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // command word
    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic signed [31:0] item_code;
        logic signed [31:0] item_amount;
        logic [31:0]        item_price_bits;
        logic [63:0]        item_name_low;
        logic [15:0]        item_name_high;
    } in_item_t;

    // result word
    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic signed [31:0] out_code;
        logic signed [31:0] out_amount;
        logic [31:0]        out_price_bits;
        logic [63:0]        out_name_low;
        logic [15:0]        out_name_high;
        logic [OCC_W-1:0]   occupancy;
        logic               last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic            accept;       // latch the command word
        logic            push;         // write record at tail
        logic            pop;          // drop the head entry
        logic            walk_begin;   // start a walk at the head
        logic            issue;        // read the entry under the walk pointer
        logic            emit_entry;   // emit the entry read last cycle
        logic            last_entry;   // that entry is the final one
        logic            update;       // apply the key match to the entry read last cycle
        logic            sub;          // subtract rather than add
        logic            emit_simple;  // emit a status-only word
        logic [ST_W-1:0] status;       // status of that word
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic issue_last;   // the read being issued is the final one
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/rfku_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfku_datapath: entry memories, ring pointers and result register
// Stores records in a ring, walks it one entry per cycle through a registered
// read port, applies keyed amount updates and builds the result words.
// ----------------------------------------------------------------------------
module rfku_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rfku_pkg::in_item_t item,
    input  wire rfku_pkg::dp_cmd_t  cmd,
    output rfku_pkg::dp_status_t    stat,
    output rfku_pkg::out_item_t     result,
    output logic                    strobe
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [31:0] code;
        logic [31:0] price;
        logic [63:0] name_low;
        logic [15:0] name_high;
    } rec_t;

    rec_t        rec_mem [DEPTH];
    logic [31:0] amt_mem [DEPTH];

    logic [IDX_W-1:0] head_reg,   head_next;
    logic [IDX_W-1:0] tail_reg,   tail_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [IDX_W-1:0] ptr_reg,    ptr_next;
    logic [CNT_W-1:0] issued_reg, issued_next;
    logic [IDX_W-1:0] proc_addr_reg;
    rec_t             rec_q_reg;
    logic [31:0]      amt_q_reg;
    logic [31:0]      key_reg;
    logic [31:0]      delta_reg;
    rfku_pkg::out_item_t result_reg, result_next;
    logic             strobe_reg, strobe_next;

    logic             match;
    logic [31:0]      amt_new;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // status towards the controller
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.issue_last = (CNT_W'(issued_reg + 1'b1) == count_reg);

    // pointer and count updates
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        issued_next = issued_reg;
        if (cmd.push)
        begin
            tail_next  = ring_next(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            head_next  = ring_next(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.walk_begin)
        begin
            ptr_next    = head_reg;
            issued_next = '0;
        end
        if (cmd.issue)
        begin
            ptr_next    = ring_next(ptr_reg);
            issued_next = issued_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            issued_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            issued_reg <= issued_next;
            strobe_reg <= strobe_next;
        end
    end

    // hold the key and quantity of the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg   <= item.item_code;
            delta_reg <= item.item_amount;
        end
    end

    // keyed amount update on the entry read last cycle
    assign match   = (rec_q_reg.code == key_reg);
    assign amt_new = cmd.sub ? (amt_q_reg - delta_reg) : (amt_q_reg + delta_reg);

    // record memory: write on push, registered read on walk
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            rec_mem[tail_reg] <= '{code:      item.item_code,
                                   price:     item.item_price_bits,
                                   name_low:  item.item_name_low,
                                   name_high: item.item_name_high};
        end
        if (cmd.issue)
        begin
            rec_q_reg     <= rec_mem[ptr_reg];
            proc_addr_reg <= ptr_reg;
        end
    end

    // amount memory: write on push or matching update, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            amt_mem[tail_reg] <= item.item_amount;
        end
        else if (cmd.update && match)
        begin
            amt_mem[proc_addr_reg] <= amt_new;
        end
        if (cmd.issue)
        begin
            amt_q_reg <= amt_mem[ptr_reg];
        end
    end

    // build the result word
    always_comb
    begin
        result_next = result_reg;
        strobe_next = 1'b0;
        if (cmd.emit_simple)
        begin
            result_next           = '0;
            result_next.status    = cmd.status;
            result_next.occupancy = rfku_pkg::OCC_W'(count_next);
            result_next.last      = 1'b1;
            strobe_next           = 1'b1;
        end
        else if (cmd.emit_entry)
        begin
            result_next.status         = rfku_pkg::ST_OK;
            result_next.out_code       = rec_q_reg.code;
            result_next.out_amount     = amt_q_reg;
            result_next.out_price_bits = rec_q_reg.price;
            result_next.out_name_low   = rec_q_reg.name_low;
            result_next.out_name_high  = rec_q_reg.name_high;
            result_next.occupancy      = rfku_pkg::OCC_W'(count_next);
            result_next.last           = cmd.last_entry;
            strobe_next                = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule
`default_nettype wire

// ===== design/rfku_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfku_ctrl: operation sequencer for the record queue
// Decodes each accepted word, issues push and pop straight from idle, and runs the
// read walk used by dump, subtract and add.
// ----------------------------------------------------------------------------
module rfku_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rfku_pkg::OP_W-1:0]     opcode,
    input  wire rfku_pkg::dp_status_t          stat,
    output rfku_pkg::dp_cmd_t                  cmd,
    output logic                               busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [rfku_pkg::OP_W-1:0] op_reg,    op_next;
    logic                      proc_valid_reg;
    logic                      is_dump;

    assign is_dump = (op_reg == rfku_pkg::OP_DUMP);
    assign busy    = (state_reg != S_IDLE);

    // decode and sequence
    always_comb
    begin
        cmd        = '0;
        cmd.status = rfku_pkg::ST_OK;
        cmd.sub    = (op_reg == rfku_pkg::OP_SUB);
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    op_next    = opcode;
                    unique case (opcode)
                        rfku_pkg::OP_PUSH:
                        begin
                            cmd.emit_simple = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = rfku_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        rfku_pkg::OP_POP:
                        begin
                            cmd.emit_simple = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.status = rfku_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop = 1'b1;
                            end
                        end
                        rfku_pkg::OP_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_simple = 1'b1;
                                cmd.status      = rfku_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.walk_begin = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                        rfku_pkg::OP_SUB,
                        rfku_pkg::OP_ADD:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_simple = 1'b1;
                            end
                            else
                            begin
                                cmd.walk_begin = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                        default:
                        begin
                            cmd.emit_simple = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // issue the next read, handle the previous one
                cmd.issue      = 1'b1;
                cmd.emit_entry = proc_valid_reg && is_dump;
                cmd.update     = proc_valid_reg && !is_dump;
                if (stat.issue_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // handle the final read and close the operation
                cmd.emit_entry  = is_dump;
                cmd.last_entry  = 1'b1;
                cmd.update      = !is_dump;
                cmd.emit_simple = !is_dump;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= rfku_pkg::OP_PUSH;
            proc_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            proc_valid_reg <= cmd.issue;
        end
    end

endmodule
`default_nettype wire

// ===== design/record_fifo_with_keyed_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// record_fifo_with_keyed_update: bounded queue of product records
// Ring of DEPTH records with push, pop, dump and keyed subtract/add.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Results appear
// on result, each marked by strobe for a single cycle, and must be taken then;
// the receiver cannot hold them off. Push, pop, unused codes and any operation
// on an empty queue leave busy low: the single result shows in the next cycle
// and a new word may be taken in that same cycle. Dump, subtract and add keep
// busy high through the walk and the closing flush state; the walk reads one
// stored entry per cycle through the single read port of the entry memory.
// Dump on a queue of N entries gives N results on consecutive cycles, the
// final one with last set. Entries are never cleared: only occupied entries
// are ever read.
// ----------------------------------------------------------------------------
module record_fifo_with_keyed_update #(
    parameter int DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire rfku_pkg::in_item_t  item,
    output rfku_pkg::out_item_t      result,
    output logic                     strobe
);

    rfku_pkg::dp_cmd_t    cmd;
    rfku_pkg::dp_status_t stat;

    // sequencer
    rfku_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // storage and result path
    rfku_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule
`default_nettype wire
